### rtl/gpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants for the glyph pixel blend/pack block.
// ----------------------------------------------------------------------------
package gpb_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W         = 24;
    localparam int CH_W            = 8;
    localparam int PIX_W           = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 5;

    // input commands
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_RENDER  = 1'b1;

    // pixel depth codes (code 3 acts as 32 bpp)
    localparam logic [1:0] MODE_8BPP  = 2'd0;
    localparam logic [1:0] MODE_16BPP = 2'd1;
    localparam logic [1:0] MODE_32BPP = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_OFFSET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LENGTH  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_OFFSET  = 3'd6;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] red_len;
        logic [4:0] red_off;
        logic [3:0] green_len;
        logic [4:0] green_off;
        logic [3:0] blue_len;
        logic [4:0] blue_off;
    } cfg_t;

endpackage

### rtl/gpb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gpb_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_chan
// One color channel: registered coverage product, then divide by 255 and
// add/subtract onto the background value; mono mode passes fg or bg as selected.
// ----------------------------------------------------------------------------
module gpb_chan (
    input  logic                   clk,
    input  logic                   en,
    input  logic [gpb_pkg::CH_W-1:0] fg_ch,
    input  logic [gpb_pkg::CH_W-1:0] bg_ch,
    input  logic [gpb_pkg::CH_W-1:0] coverage,
    input  logic                   mono,
    input  logic                   is_fg,
    output logic [gpb_pkg::CH_W-1:0] ch
);

    logic [gpb_pkg::CH_W-1:0]   base_reg, base_next;
    logic                       neg_reg, neg_next;
    logic [2*gpb_pkg::CH_W-1:0] prod_reg, prod_next;
    logic [gpb_pkg::CH_W-1:0]   diff;
    logic [2*gpb_pkg::CH_W-1:0] quot_sum;
    logic [gpb_pkg::CH_W-1:0]   quot;

    always_comb
    begin
        diff      = (fg_ch >= bg_ch) ? (fg_ch - bg_ch) : (bg_ch - fg_ch);
        base_next = mono ? (is_fg ? fg_ch : bg_ch) : bg_ch;
        neg_next  = !mono && (fg_ch < bg_ch);
        prod_next = mono ? '0 : (16'(diff) * 16'(coverage));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            neg_reg  <= neg_next;
            prod_reg <= prod_next;
        end
    end

    // x / 255 == (x + (x >> 8) + 1) >> 8, exact for x up to 255*255
    always_comb
    begin
        quot_sum = prod_reg + (prod_reg >> 8) + 16'd1;
        quot     = quot_sum[15:8];
        ch       = neg_reg ? (base_reg - quot) : (base_reg + quot);
    end

endmodule

### rtl/gpb_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_pack
// Packs three channels into a pixel word by length/offset and depth mode.
// ----------------------------------------------------------------------------
module gpb_pack (
    input  gpb_pkg::cfg_t            cfg,
    input  logic [gpb_pkg::CH_W-1:0] red,
    input  logic [gpb_pkg::CH_W-1:0] green,
    input  logic [gpb_pkg::CH_W-1:0] blue,
    input  logic [gpb_pkg::CH_W-1:0] index,
    output logic [gpb_pkg::PIX_W-1:0] pixel
);

    function automatic logic [gpb_pkg::PIX_W-1:0] place(
        input logic [gpb_pkg::CH_W-1:0] v,
        input logic [3:0]               len,
        input logic [4:0]               off
    );
        logic [3:0]               len_c;
        logic [gpb_pkg::CH_W-1:0] kept;
        len_c = (len > 4'd8) ? 4'd8 : len;
        kept  = v >> (4'd8 - len_c);
        // bits shifted past the top of the word are dropped
        return gpb_pkg::PIX_W'(kept) << off;
    endfunction

    logic [gpb_pkg::PIX_W-1:0] packed_word;

    always_comb
    begin
        packed_word = place(red, cfg.red_len, cfg.red_off)
                    | place(green, cfg.green_len, cfg.green_off)
                    | place(blue, cfg.blue_len, cfg.blue_off);
        unique case (cfg.mode)
            gpb_pkg::MODE_8BPP:  pixel = gpb_pkg::PIX_W'(index);
            gpb_pkg::MODE_16BPP: pixel = {16'd0, packed_word[15:0]};
            default:             pixel = packed_word;
        endcase
    end

endmodule

### rtl/glyph_pixel_blend_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_pixel_blend_pack
// Colors one glyph pixel: palette lookup, coverage blend, channel packing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | command, entry_*, fg/bg_index, coverage, flags
//  out     | output    | out_valid/out_ready| pixel_value, write_enable
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  One item per clock unless out_ready stalls the output; after acceptance a render
//  result passes palette read, coverage multiply, divide/pack into the output register.
//  Palette writes land in both palette copies at the acceptance edge and give
//  no result. Palette depth sets two 1R1W RAM copies (fg and bg read ports).
//  Each stage loads when empty or when the stage after it moves, so bubbles fill
//  under output stall. Reset clears valids and cfg_reg, not data registers or palette.
// ----------------------------------------------------------------------------
module glyph_pixel_blend_pack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gpb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [7:0]                          entry_index,
    input  logic [7:0]                          entry_red,
    input  logic [7:0]                          entry_green,
    input  logic [7:0]                          entry_blue,
    input  logic [7:0]                          fg_index,
    input  logic [7:0]                          bg_index,
    input  logic [7:0]                          coverage,
    input  logic                                mono_mode,
    input  logic                                fill_background,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [31:0]                         pixel_value,
    output logic                                write_enable
);

    gpb_pkg::cfg_t cfg_reg;

    logic en1, en2, en3;
    logic pal_we;
    logic in_accept;

    logic [gpb_pkg::COLOR_W-1:0] fg_rdata, bg_rdata;
    logic [gpb_pkg::COLOR_W-1:0] fg_color, bg_color;

    // stage 1: palette read data and render fields
    logic       v1_reg;
    logic [7:0] cov1_reg, fgi1_reg, bgi1_reg;
    logic       mono1_reg, fill1_reg, fg_ok1_reg, bg_ok1_reg;
    logic       is_fg1;

    // stage 2: products (in channel units) and selection
    logic       v2_reg;
    logic       fill2_reg, is_fg2_reg;
    logic [7:0] idx2_reg;
    logic [7:0] red2, green2, blue2;

    // stage 3: output register
    logic        v3_reg;
    logic [31:0] pix_reg, pix_next;
    logic        we_reg;

    assign en3       = !v3_reg || out_ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign in_accept = in_valid && in_ready;
    assign pal_we    = in_accept && (command == gpb_pkg::CMD_PALETTE)
                    && ({1'b0, entry_index} < 9'(gpb_pkg::PALETTE_ENTRIES));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= gpb_pkg::MODE_32BPP;
            cfg_reg.red_len   <= 4'd8;
            cfg_reg.red_off   <= 5'd16;
            cfg_reg.green_len <= 4'd8;
            cfg_reg.green_off <= 5'd8;
            cfg_reg.blue_len  <= 4'd8;
            cfg_reg.blue_off  <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gpb_pkg::REG_DEPTH_MODE:   cfg_reg.mode      <= cfg_data[1:0];
                gpb_pkg::REG_RED_LENGTH:   cfg_reg.red_len   <= cfg_data[3:0];
                gpb_pkg::REG_RED_OFFSET:   cfg_reg.red_off   <= cfg_data;
                gpb_pkg::REG_GREEN_LENGTH: cfg_reg.green_len <= cfg_data[3:0];
                gpb_pkg::REG_GREEN_OFFSET: cfg_reg.green_off <= cfg_data;
                gpb_pkg::REG_BLUE_LENGTH:  cfg_reg.blue_len  <= cfg_data[3:0];
                gpb_pkg::REG_BLUE_OFFSET:  cfg_reg.blue_off  <= cfg_data;
                default: ;
            endcase
        end
    end

    // palette copies, one per read port
    gpb_ram #(
        .WIDTH (gpb_pkg::COLOR_W),
        .DEPTH (gpb_pkg::PALETTE_ENTRIES)
    ) u_pal_fg (
        .clk   (clk),
        .we    (pal_we),
        .waddr (entry_index[gpb_pkg::PAL_ADDR_W-1:0]),
        .wdata ({entry_red, entry_green, entry_blue}),
        .re    (en1),
        .raddr (fg_index[gpb_pkg::PAL_ADDR_W-1:0]),
        .rdata (fg_rdata)
    );

    gpb_ram #(
        .WIDTH (gpb_pkg::COLOR_W),
        .DEPTH (gpb_pkg::PALETTE_ENTRIES)
    ) u_pal_bg (
        .clk   (clk),
        .we    (pal_we),
        .waddr (entry_index[gpb_pkg::PAL_ADDR_W-1:0]),
        .wdata ({entry_red, entry_green, entry_blue}),
        .re    (en1),
        .raddr (bg_index[gpb_pkg::PAL_ADDR_W-1:0]),
        .rdata (bg_rdata)
    );

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid && (command == gpb_pkg::CMD_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cov1_reg   <= coverage;
            fgi1_reg   <= fg_index;
            bgi1_reg   <= bg_index;
            mono1_reg  <= mono_mode;
            fill1_reg  <= fill_background;
            fg_ok1_reg <= {1'b0, fg_index} < 9'(gpb_pkg::PALETTE_ENTRIES);
            bg_ok1_reg <= {1'b0, bg_index} < 9'(gpb_pkg::PALETTE_ENTRIES);
        end
    end

    always_comb
    begin
        fg_color = fg_ok1_reg ? fg_rdata : '0;
        bg_color = bg_ok1_reg ? bg_rdata : '0;
        if (cfg_reg.mode == gpb_pkg::MODE_8BPP)
        begin
            is_fg1 = mono1_reg ? (cov1_reg != 8'd0) : cov1_reg[7];
        end
        else
        begin
            is_fg1 = (cov1_reg != 8'd0);
        end
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            fill2_reg  <= fill1_reg;
            is_fg2_reg <= is_fg1;
            idx2_reg   <= is_fg1 ? fgi1_reg : bgi1_reg;
        end
    end

    gpb_chan u_chan_red (
        .clk      (clk),
        .en       (en2),
        .fg_ch    (fg_color[23:16]),
        .bg_ch    (bg_color[23:16]),
        .coverage (cov1_reg),
        .mono     (mono1_reg),
        .is_fg    (is_fg1),
        .ch       (red2)
    );

    gpb_chan u_chan_green (
        .clk      (clk),
        .en       (en2),
        .fg_ch    (fg_color[15:8]),
        .bg_ch    (bg_color[15:8]),
        .coverage (cov1_reg),
        .mono     (mono1_reg),
        .is_fg    (is_fg1),
        .ch       (green2)
    );

    gpb_chan u_chan_blue (
        .clk      (clk),
        .en       (en2),
        .fg_ch    (fg_color[7:0]),
        .bg_ch    (bg_color[7:0]),
        .coverage (cov1_reg),
        .mono     (mono1_reg),
        .is_fg    (is_fg1),
        .ch       (blue2)
    );

    gpb_pack u_pack (
        .cfg   (cfg_reg),
        .red   (red2),
        .green (green2),
        .blue  (blue2),
        .index (idx2_reg),
        .pixel (pix_next)
    );

    // stage 3: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            pix_reg <= pix_next;
            we_reg  <= fill2_reg || is_fg2_reg;
        end
    end

    assign out_valid    = v3_reg;
    assign pixel_value  = pix_reg;
    assign write_enable = we_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_palette_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == gpb_pkg::CMD_PALETTE) |=> !v1_reg)
        else $error("palette write entered render pipeline");

    a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == gpb_pkg::CMD_RENDER) |=> v1_reg)
        else $error("render transaction lost at entry");

    a_8bpp_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cfg_reg.mode == gpb_pkg::MODE_8BPP) |-> (pixel_value[31:8] == 24'd0))
        else $error("8 bpp pixel wider than index");

    a_16bpp_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cfg_reg.mode == gpb_pkg::MODE_16BPP) |-> (pixel_value[31:16] == 16'd0))
        else $error("16 bpp pixel not masked");
`endif

endmodule
